### hw/rtl/uart_ri_pkg.sv
package uart_ri_pkg;

  localparam int unsigned UART_FIFO_DEPTH = 64;
  localparam int unsigned UART_REG_BYTES  = 1;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_LINE  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    OFF_RX_TX   = 3'd0,
    OFF_IER     = 3'd1,
    OFF_IIR_FCR = 3'd2,
    OFF_LCR     = 3'd3,
    OFF_MCR     = 3'd4,
    OFF_LSR     = 3'd5,
    OFF_MSR     = 3'd6,
    OFF_SCR     = 3'd7
  } reg_off_t;

  localparam logic [7:0] DLL_RESET = 8'h0C;
  localparam logic [7:0] MCR_RESET = 8'h08;
  localparam logic [7:0] LSR_RESET = 8'h60;
  localparam logic [7:0] MSR_VALUE = 8'hB0;
  localparam logic [7:0] IIR_FIXED = 8'hC0;
  localparam logic [3:0] IER_MASK  = 4'hF;

  localparam logic [3:0] IIR_NONE  = 4'h1;
  localparam logic [3:0] IIR_THRE  = 4'h2;
  localparam logic [3:0] IIR_RDA   = 4'h4;

  localparam logic [7:0] LSR_DR    = 8'h01;
  localparam logic [7:0] LSR_TXE   = 8'h60;
  localparam logic [7:0] LSR_TEMT  = 8'h40;

  localparam int unsigned LCR_DLAB_BIT = 7;
  localparam int unsigned MCR_LOOP_BIT = 4;
  localparam int unsigned FCR_EN_BIT   = 0;
  localparam int unsigned FCR_RXCLR_BIT = 1;
  localparam int unsigned FCR_TXCLR_BIT = 2;
  localparam int unsigned IER_RDA_BIT  = 0;
  localparam int unsigned IER_THRE_BIT = 1;

endpackage

### hw/rtl/uart_register_interface.sv
// 16550-style UART register block. Each request is a bus read, a bus write
// or a byte from the serial line, and produces exactly one result. A request
// is taken into an input register, decoded and applied to the register file
// and the receive FIFO as it leaves that register, and its result is held in
// an output register: one request per cycle is sustained while the output is
// not stalled. The receive FIFO is a FIFO_DEPTH-entry memory with a registered
// read port that always holds the entry at the head, so a receive-buffer
// read pops without extra latency. The register offset is
// (address >> shift) & 7; the shift amount is written on the cfg port,
// which is always ready and must be written only while no request is in
// flight. Accesses whose size differs from REG_WIDTH_BYTES return bus_error
// and change nothing.
module uart_register_interface #(
  parameter int unsigned FIFO_DEPTH      = uart_ri_pkg::UART_FIFO_DEPTH,
  parameter int unsigned REG_WIDTH_BYTES = uart_ri_pkg::UART_REG_BYTES
) (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_kind,
  input  logic [5:0] in_address,
  input  logic [3:0] in_access_size,
  input  logic [7:0] in_wdata,
  input  logic [7:0] in_line_byte,

  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_rdata,
  output logic       out_bus_error,
  output logic       out_tx_valid,
  output logic [7:0] out_tx_data,
  output logic       out_line_accepted,
  output logic       out_irq,

  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data
);
  import uart_ri_pkg::*;

  localparam int unsigned PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned SW = PW + 1;

  // input register
  logic       in_v_r;
  logic [1:0] in_kind_r;
  logic [5:0] in_address_r;
  logic [3:0] in_size_r;
  logic [7:0] in_wdata_r;
  logic [7:0] in_line_r;

  // output register
  logic       out_valid_r;
  logic [7:0] out_rdata_r;
  logic       out_bus_error_r;
  logic       out_tx_valid_r;
  logic [7:0] out_tx_data_r;
  logic       out_line_accepted_r;
  logic       out_irq_r;

  // register file
  logic [1:0] shift_r;
  logic [7:0] dll_r, dll_nxt;
  logic [7:0] dlm_r, dlm_nxt;
  logic [3:0] ier_r, ier_nxt;
  logic [3:0] iir_r, iir_nxt;
  logic [7:0] fcr_r, fcr_nxt;
  logic [7:0] lcr_r, lcr_nxt;
  logic [7:0] mcr_r, mcr_nxt;
  logic [7:0] lsr_r, lsr_nxt;
  logic [7:0] scr_r, scr_nxt;
  logic       irq_r, irq_nxt;

  // receive FIFO
  logic [7:0]    rx_mem [FIFO_DEPTH];
  logic [7:0]    rx_rd_r;
  logic [CW-1:0] rx_count_r, rx_count_nxt;
  logic [PW-1:0] rx_head_r, rx_head_nxt;
  logic [PW-1:0] rx_head_inc;
  logic [PW-1:0] rx_tail;
  logic [SW-1:0] tail_sum;
  logic          rx_we;
  logic [7:0]    rx_wdata;
  logic          rx_not_full;

  logic       accept;
  logic       process;
  logic [7:0] rdata_nxt;
  logic       err_nxt;
  logic       txv_nxt;
  logic [7:0] txd_nxt;
  logic       acc_nxt;

  assign accept   = in_valid && !in_stall;
  assign process  = in_v_r && !(out_valid_r && out_stall);
  assign in_stall = in_v_r && out_valid_r && out_stall;
  assign cfg_ready = 1'b1;

  assign out_valid         = out_valid_r;
  assign out_rdata         = out_rdata_r;
  assign out_bus_error     = out_bus_error_r;
  assign out_tx_valid      = out_tx_valid_r;
  assign out_tx_data       = out_tx_data_r;
  assign out_line_accepted = out_line_accepted_r;
  assign out_irq           = out_irq_r;

  assign tail_sum = SW'(rx_head_r) + SW'(rx_count_r);
  assign rx_tail  = (tail_sum >= SW'(FIFO_DEPTH)) ? PW'(tail_sum - SW'(FIFO_DEPTH))
                                                  : PW'(tail_sum);
  assign rx_head_inc = (rx_head_r == PW'(FIFO_DEPTH - 1)) ? '0 : rx_head_r + PW'(1);
  assign rx_not_full = rx_count_r < CW'(FIFO_DEPTH);

  always_comb begin
    logic     dlab;
    logic     refresh;
    reg_off_t off;
    dlab    = lcr_r[LCR_DLAB_BIT];
    off     = reg_off_t'(3'(in_address_r >> shift_r));
    refresh = 1'b0;

    dll_nxt = dll_r;
    dlm_nxt = dlm_r;
    ier_nxt = ier_r;
    iir_nxt = iir_r;
    fcr_nxt = fcr_r;
    lcr_nxt = lcr_r;
    mcr_nxt = mcr_r;
    lsr_nxt = lsr_r;
    scr_nxt = scr_r;
    irq_nxt = irq_r;
    rx_count_nxt = rx_count_r;
    rx_head_nxt  = rx_head_r;
    rx_we    = 1'b0;
    rx_wdata = in_wdata_r;

    rdata_nxt = '0;
    err_nxt   = 1'b0;
    txv_nxt   = 1'b0;
    txd_nxt   = '0;
    acc_nxt   = 1'b0;

    if (process) begin
      unique case (kind_t'(in_kind_r))
        KIND_READ: begin
          if (in_size_r != 4'(REG_WIDTH_BYTES)) begin
            err_nxt = 1'b1;
          end else begin
            unique case (off)
              OFF_RX_TX: begin
                if (dlab) begin
                  rdata_nxt = dll_r;
                end else if (rx_count_r == '0) begin
                  lsr_nxt = lsr_nxt & ~LSR_DR;
                end else begin
                  rdata_nxt    = rx_rd_r;
                  rx_head_nxt  = rx_head_inc;
                  rx_count_nxt = rx_count_r - CW'(1);
                  if (rx_count_r == CW'(1)) begin
                    lsr_nxt = lsr_nxt & ~LSR_DR;
                  end
                end
                refresh = 1'b1;
              end
              OFF_IER:     rdata_nxt = dlab ? dlm_r : {4'h0, ier_r};
              OFF_IIR_FCR: rdata_nxt = {4'h0, iir_r} | IIR_FIXED;
              OFF_LCR:     rdata_nxt = lcr_r;
              OFF_MCR:     rdata_nxt = mcr_r;
              OFF_LSR:     rdata_nxt = lsr_r;
              OFF_MSR:     rdata_nxt = MSR_VALUE;
              OFF_SCR:     rdata_nxt = scr_r;
            endcase
          end
        end
        KIND_WRITE: begin
          if (in_size_r != 4'(REG_WIDTH_BYTES)) begin
            err_nxt = 1'b1;
          end else begin
            unique case (off)
              OFF_RX_TX: begin
                if (dlab) begin
                  dll_nxt = in_wdata_r;
                end else if (mcr_r[MCR_LOOP_BIT]) begin
                  if (rx_not_full) begin
                    rx_we        = 1'b1;
                    rx_count_nxt = rx_count_r + CW'(1);
                    lsr_nxt      = lsr_nxt | LSR_DR;
                  end
                end else begin
                  lsr_nxt = lsr_nxt | LSR_TXE;
                  txv_nxt = 1'b1;
                  txd_nxt = in_wdata_r;
                end
                refresh = 1'b1;
              end
              OFF_IER: begin
                if (dlab) begin
                  dlm_nxt = in_wdata_r;
                end else begin
                  ier_nxt = in_wdata_r[3:0] & IER_MASK;
                end
                refresh = 1'b1;
              end
              OFF_IIR_FCR: begin
                fcr_nxt = in_wdata_r;
                refresh = 1'b1;
              end
              OFF_LCR: begin
                lcr_nxt = in_wdata_r;
                refresh = 1'b1;
              end
              OFF_MCR: begin
                mcr_nxt = in_wdata_r;
                refresh = 1'b1;
              end
              OFF_LSR, OFF_MSR: ;
              OFF_SCR: scr_nxt = in_wdata_r;
            endcase
          end
        end
        KIND_LINE: begin
          if (fcr_r[FCR_EN_BIT] && !mcr_r[MCR_LOOP_BIT] && rx_not_full) begin
            rx_we        = 1'b1;
            rx_wdata     = in_line_r;
            rx_count_nxt = rx_count_r + CW'(1);
            lsr_nxt      = lsr_nxt | LSR_DR;
            acc_nxt      = 1'b1;
            refresh      = 1'b1;
          end
        end
        default: ;
      endcase

      if (refresh) begin
        if (fcr_nxt[FCR_RXCLR_BIT]) begin
          fcr_nxt[FCR_RXCLR_BIT] = 1'b0;
          rx_count_nxt = '0;
          rx_head_nxt  = '0;
          lsr_nxt      = lsr_nxt & ~LSR_DR;
        end
        if (fcr_nxt[FCR_TXCLR_BIT]) begin
          fcr_nxt[FCR_TXCLR_BIT] = 1'b0;
          lsr_nxt = lsr_nxt | LSR_TXE;
        end
        if (ier_nxt[IER_RDA_BIT] && (lsr_nxt & LSR_DR) != '0) begin
          iir_nxt = IIR_RDA;
        end else if (ier_nxt[IER_THRE_BIT] && (lsr_nxt & LSR_TEMT) != '0) begin
          iir_nxt = IIR_THRE;
        end else begin
          iir_nxt = IIR_NONE;
        end
        irq_nxt = (iir_nxt != IIR_NONE);
        if (!ier_nxt[IER_THRE_BIT]) begin
          lsr_nxt = lsr_nxt | LSR_TXE;
        end
      end
    end
  end

  // head entry prefetch, with bypass for a push into an empty FIFO
  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[rx_tail] <= rx_wdata;
    end
    if (rx_we && rx_tail == rx_head_nxt) begin
      rx_rd_r <= rx_wdata;
    end else begin
      rx_rd_r <= rx_mem[rx_head_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      shift_r     <= '0;
      dll_r       <= DLL_RESET;
      dlm_r       <= '0;
      ier_r       <= '0;
      iir_r       <= IIR_NONE;
      fcr_r       <= '0;
      lcr_r       <= '0;
      mcr_r       <= MCR_RESET;
      lsr_r       <= LSR_RESET;
      scr_r       <= '0;
      irq_r       <= 1'b0;
      rx_count_r  <= '0;
      rx_head_r   <= '0;
    end else begin
      in_v_r      <= accept || (in_v_r && !process);
      out_valid_r <= process || (out_valid_r && out_stall);
      if (cfg_valid && cfg_ready) begin
        shift_r <= cfg_data;
      end
      dll_r      <= dll_nxt;
      dlm_r      <= dlm_nxt;
      ier_r      <= ier_nxt;
      iir_r      <= iir_nxt;
      fcr_r      <= fcr_nxt;
      lcr_r      <= lcr_nxt;
      mcr_r      <= mcr_nxt;
      lsr_r      <= lsr_nxt;
      scr_r      <= scr_nxt;
      irq_r      <= irq_nxt;
      rx_count_r <= rx_count_nxt;
      rx_head_r  <= rx_head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_kind_r    <= in_kind;
      in_address_r <= in_address;
      in_size_r    <= in_access_size;
      in_wdata_r   <= in_wdata;
      in_line_r    <= in_line_byte;
    end
    if (process) begin
      out_rdata_r         <= rdata_nxt;
      out_bus_error_r     <= err_nxt;
      out_tx_valid_r      <= txv_nxt;
      out_tx_data_r       <= txd_nxt;
      out_line_accepted_r <= acc_nxt;
      out_irq_r           <= irq_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rx_count_r <= CW'(FIFO_DEPTH))
    else $error("receive count above depth");

  a_irq_matches_iir: assert property (@(posedge clk) disable iff (!rst_n)
    irq_r == (iir_r != IIR_NONE))
    else $error("irq level disagrees with interrupt identity");

  a_dr_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    (lsr_r & LSR_DR) != '0 |-> rx_count_r != '0)
    else $error("data ready set with empty receive FIFO");

  a_one_effect: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_tx_valid_r && out_line_accepted_r) &&
                    !(out_bus_error_r && out_tx_valid_r))
    else $error("result carries conflicting effects");
`endif

endmodule
